@@ hw/rtl/assert_macros.svh @@
// assertion helper macros for the pupil modulator checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, quiet during reset
`define QPPM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qppm assertion failed");

// next-cycle implication, sampled on i_clk, quiet during reset
`define QPPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qppm assertion failed");

`endif

@@ hw/rtl/qppm_pkg.sv @@
// ----------------------------------------------------------------------------
// qppm_pkg
// shared types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package qppm_pkg;

    localparam int CORDIC_STAGES = 18;
    localparam int ATAN_ENTRIES  = 30;
    localparam int NUM_CELLS     = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;
    localparam int GRID_SIZE     = 64;

    // register indexes
    localparam logic [2:0] REG_COEF_X   = 3'd0;
    localparam logic [2:0] REG_COEF_Y   = 3'd1;
    localparam logic [2:0] REG_COEF_XX  = 3'd2;
    localparam logic [2:0] REG_COEF_YY  = 3'd3;
    localparam logic [2:0] REG_COEF_XY  = 3'd4;
    localparam logic [2:0] REG_ORIGIN_X = 3'd5;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd6;
    localparam logic [2:0] REG_STEP_DX  = 3'd7;

    // cordic start value, 1/gain in q2.30
    localparam logic signed [33:0] CORDIC_INIT = 34'sd652032874;

    typedef struct packed {
        logic signed [31:0] coef_x;
        logic signed [31:0] coef_y;
        logic signed [31:0] coef_xx;
        logic signed [31:0] coef_yy;
        logic signed [31:0] coef_xy;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic        [30:0] step_dx;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
    } t_pixel;

    typedef struct packed {
        logic               outside;
        logic               flip;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        t_pixel             pix;
    } t_cordic;

    // pipeline advance control shared by all stages
    typedef struct packed {
        logic en;
    } t_pipe_ctl;

    // arctangent of 2^-i in q0.32 turns
    function automatic logic signed [33:0] atan_turn(input logic [4:0] idx);
        logic signed [33:0] v;
        case (idx)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;
            5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;
            5'd27: v = 34'sd5;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/qppm_pix_if.sv @@
// ----------------------------------------------------------------------------
// qppm_pix_if
// input request channel: pixel with grid position
// ----------------------------------------------------------------------------
interface qppm_pix_if;
    logic               valid;
    logic               ready;
    logic        [5:0]  column;
    logic        [5:0]  row;
    logic signed [15:0] pixel_re;
    logic signed [15:0] pixel_im;

    modport source (output valid, column, row, pixel_re, pixel_im, input ready);
    modport sink   (input valid, column, row, pixel_re, pixel_im, output ready);
endinterface

@@ hw/rtl/qppm_res_if.sv @@
// ----------------------------------------------------------------------------
// qppm_res_if
// output request channel: rotated pixel
// ----------------------------------------------------------------------------
interface qppm_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;

    modport source (output valid, out_re, out_im, input ready);
    modport sink   (input valid, out_re, out_im, output ready);
endinterface

@@ hw/rtl/qppm_phase.sv @@
// ----------------------------------------------------------------------------
// qppm_phase
// coordinates, quadratic phase mod one turn and cordic pre-rotation, 4 stages
// ----------------------------------------------------------------------------
module qppm_phase import qppm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  logic      i_valid,
    input  logic [5:0] i_col,
    input  logic [5:0] i_row,
    input  t_pixel    i_pix,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    output t_cordic   o_d
);

    // saturate a 39 bit coordinate to q8.24
    function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
        logic signed [31:0] r;
        if (v > 39'sd2147483647)       r = 32'sh7fffffff;
        else if (v < -39'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

    // coef times a q.24 square, kept mod 2^44, split into two narrow products
    function automatic logic [43:0] lo_part(input logic signed [31:0] c,
                                            input logic signed [63:0] sq);
        logic signed [20:0] lo;
        logic signed [52:0] p;
        lo = $signed({1'b0, sq[43:24]});
        p  = 53'(c) * 53'(lo);
        return p[43:0];
    endfunction

    function automatic logic [23:0] hi_part(input logic signed [31:0] c,
                                            input logic signed [63:0] sq);
        logic signed [19:0] hi;
        logic signed [51:0] p;
        hi = $signed(sq[63:44]);
        p  = 52'(c) * 52'(hi);
        return p[23:0];
    endfunction

    logic               r1_v, r2_v, r3_v, r4_v;
    logic signed [31:0] r1_x, r1_y;
    t_pixel             r1_pix, r2_pix, r3_pix;
    logic               r1_out, r2_out, r3_out;
    logic signed [63:0] r2_xx, r2_yy, r2_xy, r2_lx, r2_ly;
    logic [43:0]        r3_lx, r3_ly, r3_xx_lo, r3_yy_lo, r3_xy_lo;
    logic [23:0]        r3_xx_hi, r3_yy_hi, r3_xy_hi;
    t_cordic            r4_d;

    logic        [36:0] w_cx, w_cy;
    logic signed [38:0] w_sx, w_sy;
    logic        [43:0] w_acc;
    logic        [31:0] w_phase;

    // stage 1: pixel coordinates
    assign w_cx = 37'(i_col) * 37'(i_cfg.step_dx);
    assign w_cy = 37'(i_row) * 37'(i_cfg.step_dx);
    assign w_sx = 39'(i_cfg.origin_x) + $signed({2'b00, w_cx});
    assign w_sy = 39'(i_cfg.origin_y) + $signed({2'b00, w_cy});

    // stage 4: phase sum and half-plane fold
    assign w_acc = r3_lx + r3_ly + r3_xx_lo + r3_yy_lo + r3_xy_lo
                 + {r3_xx_hi, 20'd0} + {r3_yy_hi, 20'd0} + {r3_xy_hi, 20'd0};
    assign w_phase = w_acc[43:12];

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_ctl.en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r1_x   <= sat32(w_sx);
            r1_y   <= sat32(w_sy);
            r1_pix <= i_pix;
            r1_out <= (9'(i_col) >= 9'(GRID_SIZE)) || (9'(i_row) >= 9'(GRID_SIZE));

            r2_xx  <= 64'(r1_x) * 64'(r1_x);
            r2_yy  <= 64'(r1_y) * 64'(r1_y);
            r2_xy  <= 64'(r1_x) * 64'(r1_y);
            r2_lx  <= 64'(i_cfg.coef_x) * 64'(r1_x);
            r2_ly  <= 64'(i_cfg.coef_y) * 64'(r1_y);
            r2_pix <= r1_pix;
            r2_out <= r1_out;

            r3_lx    <= r2_lx[43:0];
            r3_ly    <= r2_ly[43:0];
            r3_xx_lo <= lo_part(i_cfg.coef_xx, r2_xx);
            r3_yy_lo <= lo_part(i_cfg.coef_yy, r2_yy);
            r3_xy_lo <= lo_part(i_cfg.coef_xy, r2_xy);
            r3_xx_hi <= hi_part(i_cfg.coef_xx, r2_xx);
            r3_yy_hi <= hi_part(i_cfg.coef_yy, r2_yy);
            r3_xy_hi <= hi_part(i_cfg.coef_xy, r2_xy);
            r3_pix   <= r2_pix;
            r3_out   <= r2_out;

            r4_d.outside <= r3_out;
            r4_d.flip    <= w_phase[31] ^ w_phase[30];
            r4_d.x       <= CORDIC_INIT;
            r4_d.y       <= '0;
            r4_d.z       <= (w_phase[31] ^ w_phase[30])
                            ? 34'($signed({~w_phase[31], w_phase[30:0]}))
                            : 34'($signed(w_phase));
            r4_d.pix     <= r3_pix;
        end
    end

    assign o_valid = r4_v;
    assign o_d     = r4_d;

endmodule

@@ hw/rtl/qppm_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// qppm_cordic_cell
// one rotation-mode cordic micro-rotation, registered
// ----------------------------------------------------------------------------
module qppm_cordic_cell import qppm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  logic [4:0] i_shift,
    input  logic      i_valid,
    input  t_cordic   i_d,
    output logic      o_valid,
    output t_cordic   o_d
);

    logic               r_v;
    t_cordic            r_d;
    t_cordic            n_d;
    logic signed [33:0] w_xs, w_ys, w_at;

    // shifted operands, floor by arithmetic shift
    assign w_xs = i_d.x >>> i_shift;
    assign w_ys = i_d.y >>> i_shift;
    assign w_at = atan_turn(i_shift);

    // rotate toward zero residual angle
    always_comb begin
        n_d = i_d;
        if (!i_d.z[33]) begin
            n_d.x = i_d.x - w_ys;
            n_d.y = i_d.y + w_xs;
            n_d.z = i_d.z - w_at;
        end else begin
            n_d.x = i_d.x + w_ys;
            n_d.y = i_d.y - w_xs;
            n_d.z = i_d.z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_ctl.en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_v;
    assign o_d     = r_d;

endmodule

@@ hw/rtl/qppm_rotate.sv @@
// ----------------------------------------------------------------------------
// qppm_rotate
// pixel times unit phasor, round half up and saturate, output register
// ----------------------------------------------------------------------------
module qppm_rotate import qppm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  logic      i_valid,
    input  t_cordic   i_d,
    output logic      o_valid,
    output t_pixel    o_pix
);

    function automatic logic signed [15:0] rnd_sat(input logic signed [50:0] v);
        logic signed [50:0] t;
        logic signed [20:0] q;
        logic signed [15:0] r;
        t = v + 51'sd536870912;
        q = t[50:30];
        if (q > 21'sd32767)       r = 16'sh7fff;
        else if (q < -21'sd32768) r = 16'sh8000;
        else                      r = q[15:0];
        return r;
    endfunction

    logic               r1_v, r2_v;
    logic signed [49:0] r1_rc, r1_is, r1_rs, r1_ic;
    logic               r1_out;
    t_pixel             r1_pix, r2_pix;
    logic signed [33:0] w_c, w_s;
    logic signed [50:0] w_re, w_im;

    // undo the half-turn fold
    assign w_c = i_d.flip ? -i_d.x : i_d.x;
    assign w_s = i_d.flip ? -i_d.y : i_d.y;

    assign w_re = 51'(r1_rc) - 51'(r1_is);
    assign w_im = 51'(r1_rs) + 51'(r1_ic);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_ctl.en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r1_rc  <= 50'(i_d.pix.re) * 50'(w_c);
            r1_is  <= 50'(i_d.pix.im) * 50'(w_s);
            r1_rs  <= 50'(i_d.pix.re) * 50'(w_s);
            r1_ic  <= 50'(i_d.pix.im) * 50'(w_c);
            r1_out <= i_d.outside;
            r1_pix <= i_d.pix;

            // pixels off the grid pass unchanged
            if (r1_out) begin
                r2_pix <= r1_pix;
            end else begin
                r2_pix.re <= rnd_sat(w_re);
                r2_pix.im <= rnd_sat(w_im);
            end
        end
    end

    assign o_valid = r2_v;
    assign o_pix   = r2_pix;

endmodule

@@ hw/rtl/quadratic_phase_pupil_modulator.sv @@
// ----------------------------------------------------------------------------
// quadratic_phase_pupil_modulator
// rotates each pupil pixel by a quadratic phase through a cordic cell chain
//
//   channel  dir  handshake        payload
//   i_pix    in   valid / ready    column, row, pixel_re, pixel_im
//   o_res    out  valid / ready    out_re, out_im
//   apb      in   psel / penable   8 registers at 4*index
//
// one request per cycle sustained while results are taken; 4 phase stages,
// 18 cordic cells and 2 rotation stages
// the whole pipeline advances together; a stalled result holds every stage
// and drops i_pix.ready until taken
// synchronous active-low reset clears valid bits and config registers
// ----------------------------------------------------------------------------
module quadratic_phase_pupil_modulator import qppm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    qppm_pix_if.sink           i_pix,
    qppm_res_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [4:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    t_cfg      r_cfg;
    t_pipe_ctl w_ctl;
    logic      [2:0] w_idx;
    t_pixel    w_in_pix, w_out_pix;
    logic      w_out_v;
    logic      w_vld [0:NUM_CELLS];
    t_cordic   w_chain [0:NUM_CELLS];

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_COEF_X:   r_cfg.coef_x   <= pwdata;
                REG_COEF_Y:   r_cfg.coef_y   <= pwdata;
                REG_COEF_XX:  r_cfg.coef_xx  <= pwdata;
                REG_COEF_YY:  r_cfg.coef_yy  <= pwdata;
                REG_COEF_XY:  r_cfg.coef_xy  <= pwdata;
                REG_ORIGIN_X: r_cfg.origin_x <= pwdata;
                REG_ORIGIN_Y: r_cfg.origin_y <= pwdata;
                REG_STEP_DX:  r_cfg.step_dx  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (w_idx)
            REG_COEF_X:   prdata = r_cfg.coef_x;
            REG_COEF_Y:   prdata = r_cfg.coef_y;
            REG_COEF_XX:  prdata = r_cfg.coef_xx;
            REG_COEF_YY:  prdata = r_cfg.coef_yy;
            REG_COEF_XY:  prdata = r_cfg.coef_xy;
            REG_ORIGIN_X: prdata = r_cfg.origin_x;
            REG_ORIGIN_Y: prdata = r_cfg.origin_y;
            REG_STEP_DX:  prdata = {1'b0, r_cfg.step_dx};
            default:      prdata = '0;
        endcase
    end

    // pipeline advances unless a result is waiting
    assign w_ctl.en    = !w_out_v || o_res.ready;
    assign i_pix.ready = w_ctl.en;

    assign w_in_pix.re = i_pix.pixel_re;
    assign w_in_pix.im = i_pix.pixel_im;

    qppm_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_valid (i_pix.valid),
        .i_col   (i_pix.column),
        .i_row   (i_pix.row),
        .i_pix   (w_in_pix),
        .i_cfg   (r_cfg),
        .o_valid (w_vld[0]),
        .o_d     (w_chain[0])
    );

    // cordic cell chain
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        qppm_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_shift (5'(g)),
            .i_valid (w_vld[g]),
            .i_d     (w_chain[g]),
            .o_valid (w_vld[g+1]),
            .o_d     (w_chain[g+1])
        );
    end

    qppm_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_valid (w_vld[NUM_CELLS]),
        .i_d     (w_chain[NUM_CELLS]),
        .o_valid (w_out_v),
        .o_pix   (w_out_pix)
    );

    assign o_res.valid  = w_out_v;
    assign o_res.out_re = w_out_pix.re;
    assign o_res.out_im = w_out_pix.im;

endmodule

@@ hw/rtl/qppm_checker.sv @@
// ----------------------------------------------------------------------------
// qppm_checker
// port-level checks on the pupil modulator handshakes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qppm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // a stalled result stays offered
    `QPPM_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)

    // an empty output stage never blocks new requests
    `QPPM_ASSERT_IMPL(a_ready_when_empty, !i_out_valid, i_in_ready)

    // a waiting result freezes the pipeline input
    `QPPM_ASSERT_IMPL(a_stall_blocks, i_out_valid && !i_out_ready, !i_in_ready)

endmodule

bind quadratic_phase_pupil_modulator qppm_checker u_qppm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready)
);
